[src/csp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the cone support point pipeline.
package csp_pkg;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 31;
    localparam int MAT_W   = 21;
    localparam int WIN_W   = 7;
    localparam int LOC_W   = 34;
    localparam int SCORE_W = 35;

    localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;
    localparam logic [65:0]        TINY_SQ = 66'd4295;
    localparam longint             ONE_Q30 = 64'sd1073741824;
    localparam longint             QPI_Q30 = 64'sd843314857;

    // register decode on paddr[2]
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [8:0][MAT_W-1:0]   mat_t;
    typedef logic [2:0][COORD_W-1:0] coord3_t;

    typedef struct packed {
        mat_t               m;
        coord3_t            ctr;
        logic [COORD_W-1:0] ly;
        logic               degen;
    } sb_t;

endpackage

[src/cone_support_point_unit.sv]
`timescale 1ns / 1ps
// Throughput: one word per cycle while rsp is not stalled; depth set by the matrix
// build, two rotations and the registered argmax tree over the base samples.
// A stall on rsp holds every stage at once; req_ready falls with it.
// rst_n clears all stage valids; radius and height return to 1.0 (Q16.16).
// Top level of the cone support point pipeline.
module cone_support_point_unit #(
    parameter int SAMPLES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic               degenerate,
    output logic [6:0]         winner_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int LV = $clog2(SAMPLES);
    localparam int NP = 1 << LV;
    localparam int IW = LV;

    function automatic longint mq30(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic [63:0] sample_cs(input int k);
        longint o, oct, rem, a, x2, t, sa, ca, c, s;
        o   = 8 * k;
        oct = (o / SAMPLES) & 7;
        rem = o % SAMPLES;
        if (oct[0])
            rem = SAMPLES - rem;
        a  = rem * csp_pkg::QPI_Q30 / SAMPLES;
        x2 = mq30(a, a);
        t  = csp_pkg::ONE_Q30 - x2 / 72;
        t  = csp_pkg::ONE_Q30 - mq30(x2, t) / 42;
        t  = csp_pkg::ONE_Q30 - mq30(x2, t) / 20;
        t  = csp_pkg::ONE_Q30 - mq30(x2, t) / 6;
        sa = mq30(a, t);
        t  = csp_pkg::ONE_Q30 - x2 / 90;
        t  = csp_pkg::ONE_Q30 - mq30(x2, t) / 56;
        t  = csp_pkg::ONE_Q30 - mq30(x2, t) / 30;
        t  = csp_pkg::ONE_Q30 - mq30(x2, t) / 12;
        ca = csp_pkg::ONE_Q30 - mq30(x2, t) / 2;
        case (oct)
            0:       begin c = ca;  s = sa;  end
            1:       begin c = sa;  s = ca;  end
            2:       begin c = -sa; s = ca;  end
            3:       begin c = -ca; s = sa;  end
            4:       begin c = -ca; s = -sa; end
            5:       begin c = -sa; s = -ca; end
            6:       begin c = sa;  s = -ca; end
            default: begin c = ca;  s = -sa; end
        endcase
        return {c[31:0], s[31:0]};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic signed [31:0] cos_tab [SAMPLES];
    logic signed [31:0] sin_tab [SAMPLES];

    for (genvar k = 0; k < SAMPLES; k++)
    begin : g_tab
        localparam logic [63:0] CS = sample_cs(k);
        assign cos_tab[k] = CS[63:32];
        assign sin_tab[k] = CS[31:0];
    end

    // configuration
    logic [30:0] radius_reg;
    logic [30:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd65536;
            height_reg <= 31'd65536;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                csp_pkg::REG_RADIUS: radius_reg <= pwdata[30:0];
                csp_pkg::REG_HEIGHT: height_reg <= pwdata[30:0];
                default:             radius_reg <= radius_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == csp_pkg::REG_HEIGHT) ? {1'b0, height_reg}
                                                      : {1'b0, radius_reg};

    logic adv;
    logic out_valid_reg;
    assign adv       = !out_valid_reg || rsp_ready;
    assign req_ready = adv;

    // valid chain: s1..s6, tree, a, b, c, d
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, va_reg, vb_reg, vc_reg;
    logic vt_reg [LV+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int l = 0; l <= LV; l++)
                vt_reg[l] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= req_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vt_reg[0] <= v5_reg;
            for (int l = 1; l <= LV; l++)
                vt_reg[l] <= vt_reg[l-1];
            va_reg        <= vt_reg[LV];
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            out_valid_reg <= vc_reg;
        end
    end

    // s1: quaternion products
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    csp_pkg::coord3_t   d1_reg, c1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            yz_reg <= quat_y * quat_z;
            wx_reg <= quat_w * quat_x;
            wy_reg <= quat_w * quat_y;
            wz_reg <= quat_w * quat_z;
            d1_reg <= {dir_z, dir_y, dir_x};
            c1_reg <= {center_z, center_y, center_x};
        end
    end

    // s2: matrix in Q.14
    logic signed [34:0] a_xx, a_yy, a_zz, a_xy, a_xz, a_yz, a_wx, a_wy, a_wz;
    logic signed [34:0] e [9];
    csp_pkg::mat_t      m_next;

    assign a_xx = xx_reg;
    assign a_yy = yy_reg;
    assign a_zz = zz_reg;
    assign a_xy = xy_reg;
    assign a_xz = xz_reg;
    assign a_yz = yz_reg;
    assign a_wx = wx_reg;
    assign a_wy = wy_reg;
    assign a_wz = wz_reg;

    always_comb
    begin
        e[0] = csp_pkg::ONE_Q28 - ((a_yy + a_zz) <<< 1);
        e[1] = (a_xy - a_wz) <<< 1;
        e[2] = (a_xz + a_wy) <<< 1;
        e[3] = (a_xy + a_wz) <<< 1;
        e[4] = csp_pkg::ONE_Q28 - ((a_xx + a_zz) <<< 1);
        e[5] = (a_yz - a_wx) <<< 1;
        e[6] = (a_xz - a_wy) <<< 1;
        e[7] = (a_yz + a_wx) <<< 1;
        e[8] = csp_pkg::ONE_Q28 - ((a_xx + a_yy) <<< 1);
        for (int i = 0; i < 9; i++)
            m_next[i] = 21'((e[i] + 35'sd8192) >>> 14);
    end

    csp_pkg::mat_t    m2_reg, m3_reg;
    csp_pkg::coord3_t d2_reg, c2_reg, c3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_reg <= m_next;
            d2_reg <= d1_reg;
            c2_reg <= c1_reg;
        end
    end

    // s3: transposed matrix times direction, products
    logic signed [52:0] pr_reg [9];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    pr_reg[3*i+j] <= $signed(m2_reg[3*i+j]) * $signed(d2_reg[i]);
            m3_reg <= m2_reg;
            c3_reg <= c2_reg;
        end
    end

    // s4: local direction
    logic signed [54:0] lacc [3];
    logic signed [54:0] lrnd [3];
    logic signed [31:0] l_next [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lacc[j]   = 55'(pr_reg[j]) + 55'(pr_reg[3+j]) + 55'(pr_reg[6+j]);
            lrnd[j]   = lacc[j] + 55'sd8192;
            l_next[j] = sat32(64'($signed(lrnd[j][54:14])));
        end
    end

    logic signed [31:0] lx4_reg, lz4_reg;
    csp_pkg::sb_t       sb4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lx4_reg       <= l_next[0];
            lz4_reg       <= l_next[2];
            sb4_reg.ly    <= l_next[1];
            sb4_reg.m     <= m3_reg;
            sb4_reg.ctr   <= c3_reg;
            sb4_reg.degen <= 1'b0;
        end
    end

    // s5: squares and sample projections
    logic signed [63:0] sq_reg [3];
    logic signed [63:0] cl_reg [SAMPLES];
    logic signed [63:0] sl_reg [SAMPLES];
    csp_pkg::sb_t       sb5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= lx4_reg * lx4_reg;
            sq_reg[1] <= $signed(sb4_reg.ly) * $signed(sb4_reg.ly);
            sq_reg[2] <= lz4_reg * lz4_reg;
            for (int k = 0; k < SAMPLES; k++)
            begin
                cl_reg[k] <= cos_tab[k] * lx4_reg;
                sl_reg[k] <= sin_tab[k] * lz4_reg;
            end
            sb5_reg <= sb4_reg;
        end
    end

    // s6: short test and scores, tree level 0
    logic [65:0]        sq_sum;
    logic signed [64:0] psum [SAMPLES];

    assign sq_sum = 66'($unsigned(sq_reg[0])) + 66'($unsigned(sq_reg[1]))
                  + 66'($unsigned(sq_reg[2]));

    always_comb
    begin
        for (int k = 0; k < SAMPLES; k++)
            psum[k] = 65'(cl_reg[k]) + 65'(sl_reg[k]);
    end

    logic                      tv_reg [LV+1][NP];
    logic signed [34:0]        tp_reg [LV+1][NP];
    logic [IW-1:0]             ti_reg [LV+1][NP];
    csp_pkg::sb_t              sbt_reg [LV+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sbt_reg[0] <= '{m: sb5_reg.m, ctr: sb5_reg.ctr, ly: sb5_reg.ly,
                            degen: (sq_sum < csp_pkg::TINY_SQ)};
            for (int l = 1; l <= LV; l++)
                sbt_reg[l] <= sbt_reg[l-1];
        end
    end

    for (genvar n = 0; n < NP; n++)
    begin : g_lvl0
        if (n < SAMPLES)
        begin : g_live
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tv_reg[0][n] <= 1'b1;
                    tp_reg[0][n] <= $signed(psum[n][64:30]);
                    ti_reg[0][n] <= IW'(n);
                end
            end
        end
        else
        begin : g_pad
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tv_reg[0][n] <= 1'b0;
                    tp_reg[0][n] <= '0;
                    ti_reg[0][n] <= '0;
                end
            end
        end
    end

    for (genvar l = 1; l <= LV; l++)
    begin : g_tree
        for (genvar n = 0; n < NP; n++)
        begin : g_node
            if (n < (NP >> l))
            begin : g_cmp
                logic take_b;
                assign take_b = tv_reg[l-1][2*n+1] &&
                                (!tv_reg[l-1][2*n] ||
                                 tp_reg[l-1][2*n+1] > tp_reg[l-1][2*n]);
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        tv_reg[l][n] <= tv_reg[l-1][2*n] || tv_reg[l-1][2*n+1];
                        tp_reg[l][n] <= take_b ? tp_reg[l-1][2*n+1] : tp_reg[l-1][2*n];
                        ti_reg[l][n] <= take_b ? ti_reg[l-1][2*n+1] : ti_reg[l-1][2*n];
                    end
                end
            end
            else
            begin : g_idle
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        tv_reg[l][n] <= 1'b0;
                        tp_reg[l][n] <= '0;
                        ti_reg[l][n] <= '0;
                    end
                end
            end
        end
    end

    // a: weighted scores and base point products
    logic [IW-1:0]      idx_eff;
    logic signed [31:0] rad_s, hh2_s;

    assign idx_eff = (radius_reg == '0) ? '0 : ti_reg[LV][0];
    assign rad_s   = $signed({1'b0, radius_reg});
    assign hh2_s   = $signed({1'b0, height_reg[30:1], 1'b0});

    logic signed [66:0] sc_reg;
    logic signed [63:0] hl_reg, rc_reg, rs_reg;
    logic [IW-1:0]      ia_reg;
    csp_pkg::sb_t       sba_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_reg  <= rad_s * tp_reg[LV][0];
            hl_reg  <= hh2_s * $signed(sbt_reg[LV].ly);
            rc_reg  <= rad_s * cos_tab[idx_eff];
            rs_reg  <= rad_s * sin_tab[idx_eff];
            ia_reg  <= idx_eff;
            sba_reg <= sbt_reg[LV];
        end
    end

    // b: tip or base decision, local point
    logic                          base_win;
    logic signed [63:0]            rc_rnd, rs_rnd;
    logic signed [csp_pkg::LOC_W-1:0] h_s;

    assign base_win = sc_reg > 67'(hl_reg);
    assign rc_rnd   = rc_reg + 64'sd536870912;
    assign rs_rnd   = rs_reg + 64'sd536870912;
    assign h_s      = $signed({4'b0, height_reg[30:1]});

    logic signed [csp_pkg::LOC_W-1:0] loc_reg [3];
    logic [csp_pkg::WIN_W-1:0]        wb_reg;
    csp_pkg::sb_t                     sbb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            loc_reg[0] <= base_win ? $signed(rc_rnd[63:30]) : '0;
            loc_reg[1] <= base_win ? -h_s : h_s;
            loc_reg[2] <= base_win ? $signed(rs_rnd[63:30]) : '0;
            wb_reg     <= base_win ? csp_pkg::WIN_W'(ia_reg) + 7'd1 : '0;
            sbb_reg    <= sba_reg;
        end
    end

    // c: rotate back, products
    logic signed [54:0]        q_reg [9];
    logic [csp_pkg::WIN_W-1:0] wc_reg;
    csp_pkg::sb_t              sbc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    q_reg[3*i+j] <= $signed(sbb_reg.m[3*i+j]) * loc_reg[j];
            wc_reg  <= wb_reg;
            sbc_reg <= sbb_reg;
        end
    end

    // d: offset by centre, saturate, output word
    logic signed [56:0] wacc [3];
    logic signed [56:0] wrnd [3];
    logic signed [43:0] wsum [3];
    logic signed [31:0] pt_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wacc[i]    = 57'(q_reg[3*i]) + 57'(q_reg[3*i+1]) + 57'(q_reg[3*i+2]);
            wrnd[i]    = wacc[i] + 57'sd8192;
            wsum[i]    = 44'($signed(wrnd[i][56:14])) + 44'($signed(sbc_reg.ctr[i]));
            pt_next[i] = sbc_reg.degen ? $signed(sbc_reg.ctr[i])
                                       : sat32(64'(wsum[i]));
        end
    end

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic               dg_reg;
    logic [6:0]         wi_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= pt_next[0];
            py_reg <= pt_next[1];
            pz_reg <= pt_next[2];
            dg_reg <= sbc_reg.degen;
            wi_reg <= sbc_reg.degen ? 7'd0 : wc_reg;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign point_z      = pz_reg;
    assign degenerate   = dg_reg;
    assign winner_index = wi_reg;

endmodule

[src/csp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the cone support point pipeline, bound to the top level.
module csp_checker #(
    parameter int SAMPLES = 16
) (
    input logic       clk,
    input logic       rst_n,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       degenerate,
    input logic [6:0] winner_index
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp word dropped while stalled");

    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("req taken while pipeline stalled");

    a_degen_tip: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && degenerate |-> winner_index == 7'd0)
        else $error("short direction with nonzero winner");

    a_winner_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> winner_index <= 7'(SAMPLES))
        else $error("winner index beyond sample count");

endmodule

bind cone_support_point_unit csp_checker #(.SAMPLES(SAMPLES)) u_csp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req_ready),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .degenerate   (degenerate),
    .winner_index (winner_index)
);

[tb/csp_support_checker.sv]
`timescale 1ns / 1ps
// Checker for the cone support point unit: mirrors register writes, predicts and compares words.
module csp_support_checker #(
    parameter int SAMPLES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               degenerate,
    input  logic [6:0]         winner_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               degen;
        logic [6:0]         win;
    } support_t;

    support_t   support_q[$];
    logic [30:0] radius_r;
    logic [30:0] height_r;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint mul30(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // Taylor series over [0, pi/4]
    function automatic void trig_small(input longint x, output longint c, output longint s);
        longint x2;
        longint t;
        x2 = mul30(x, x);
        t = csp_pkg::ONE_Q30 - x2 / 72;
        t = csp_pkg::ONE_Q30 - mul30(x2, t) / 42;
        t = csp_pkg::ONE_Q30 - mul30(x2, t) / 20;
        t = csp_pkg::ONE_Q30 - mul30(x2, t) / 6;
        s = mul30(x, t);
        t = csp_pkg::ONE_Q30 - x2 / 90;
        t = csp_pkg::ONE_Q30 - mul30(x2, t) / 56;
        t = csp_pkg::ONE_Q30 - mul30(x2, t) / 30;
        t = csp_pkg::ONE_Q30 - mul30(x2, t) / 12;
        c = csp_pkg::ONE_Q30 - mul30(x2, t) / 2;
    endfunction

    function automatic void base_angle(input longint k, output longint c, output longint s);
        longint o;
        longint oct;
        longint rem;
        longint a;
        longint ca;
        longint sa;
        o = 8 * k;
        oct = (o / SAMPLES) & 7;
        rem = o % SAMPLES;
        if (oct[0])
            rem = SAMPLES - rem;
        a = rem * csp_pkg::QPI_Q30 / SAMPLES;
        trig_small(a, ca, sa);
        case (oct)
            0: begin c = ca;  s = sa;  end
            1: begin c = sa;  s = ca;  end
            2: begin c = -sa; s = ca;  end
            3: begin c = -ca; s = sa;  end
            4: begin c = -ca; s = -sa; end
            5: begin c = -sa; s = -ca; end
            6: begin c = sa;  s = -ca; end
            default: begin c = ca; s = -sa; end
        endcase
    endfunction

    function automatic support_t cone_support(
        input longint dx, input longint dy, input longint dz,
        input longint w, input longint x, input longint y, input longint z,
        input longint cx, input longint cy, input longint cz);
        longint m[3][3];
        longint d[3];
        longint ctr[3];
        longint l[3];
        longint loc[3];
        longint acc;
        longint rr;
        longint h;
        longint best_k;
        longint best_sc;
        longint best_c;
        longint best_s;
        longint c;
        longint s;
        longint sc;
        longint unsigned sq;
        support_t r;
        d = '{dx, dy, dz};
        ctr = '{cx, cy, cz};
        rr = longint'(radius_r);
        h = longint'(height_r >> 1);
        m[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
        m[0][1] = 2 * (x * y - w * z);
        m[0][2] = 2 * (x * z + w * y);
        m[1][0] = 2 * (x * y + w * z);
        m[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
        m[1][2] = 2 * (y * z - w * x);
        m[2][0] = 2 * (x * z - w * y);
        m[2][1] = 2 * (y * z + w * x);
        m[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = rnd_shift(m[i][j], 14);
        sq = 0;
        for (int j = 0; j < 3; j++)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += m[i][j] * d[i];
            l[j] = sat32(rnd_shift(acc, 14));
            sq += longint'(l[j] * l[j]);
        end
        if (sq < 64'd4295)
        begin
            r.px = ctr[0][31:0];
            r.py = ctr[1][31:0];
            r.pz = ctr[2][31:0];
            r.degen = 1'b1;
            r.win = '0;
            return r;
        end
        best_k = 0;
        best_sc = 0;
        best_c = 0;
        best_s = 0;
        for (longint k = 0; k < SAMPLES; k++)
        begin
            base_angle(k, c, s);
            sc = rr * ((c * l[0] + s * l[2]) >>> 30);
            if (k == 0 || sc > best_sc)
            begin
                best_k = k;
                best_sc = sc;
                best_c = c;
                best_s = s;
            end
        end
        if (best_sc > 2 * h * l[1])
        begin
            r.win = 7'(best_k + 1);
            loc[0] = rnd_shift(rr * best_c, 30);
            loc[1] = -h;
            loc[2] = rnd_shift(rr * best_s, 30);
        end
        else
        begin
            r.win = '0;
            loc = '{0, h, 0};
        end
        r.degen = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += m[i][j] * loc[j];
            acc = sat32(ctr[i] + rnd_shift(acc, 14));
            if (i == 0) r.px = acc[31:0];
            else if (i == 1) r.py = acc[31:0];
            else r.pz = acc[31:0];
        end
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        support_t e;
        if (!rst_n)
        begin
            radius_r <= 31'd65536;
            height_r <= 31'd65536;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == csp_pkg::REG_RADIUS)
                    radius_r <= pwdata[30:0];
                else
                    height_r <= pwdata[30:0];
            end
            if (req_valid && req_ready)
                support_q.push_back(cone_support(dir_x, dir_y, dir_z, quat_w, quat_x,
                    quat_y, quat_z, center_x, center_y, center_z));
            if (rsp_valid && rsp_ready)
            begin
                if (support_q.size() == 0)
                begin
                    $display("%0t unexpected rsp word", $realtime);
                    errors++;
                end
                else
                begin
                    e = support_q.pop_front();
                    if (point_x !== e.px) report("point_x", point_x, e.px);
                    if (point_y !== e.py) report("point_y", point_y, e.py);
                    if (point_z !== e.pz) report("point_z", point_z, e.pz);
                    if (degenerate !== e.degen) report("degenerate", degenerate, e.degen);
                    if (winner_index !== e.win) report("winner_index", winner_index, e.win);
                end
            end
            pending <= support_q.size();
        end
    end

endmodule

[tb/tb_cone_support_point_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the cone support point unit: stimulus, register phases and verdict.
module tb_cone_support_point_unit;

    localparam int LIMIT = 400000;

    typedef struct {
        logic signed [31:0] d[3];
        logic signed [15:0] q[4];
        logic signed [31:0] c[3];
    } query_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    logic signed [31:0] point_x, point_y, point_z;
    logic degenerate;
    logic [6:0] winner_index;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int errors;
    int pending;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    query_t query_q[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cone_support_point_unit dut (.*);

    csp_support_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall pattern changes with cycles[9:8]
    always @(posedge clk)
    begin
        case (cycles[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= $urandom_range(0, 3) != 0;
            2'd2: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= cycles[4:2] != 3'd0;
        endcase
    end

    // sender: bursts of words with gaps between
    always @(posedge clk)
    begin
        query_t w;
        if (rst_n && (!req_valid || req_ready))
        begin
            if (gap_left > 0 || query_q.size() == 0)
            begin
                req_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                w = query_q.pop_front();
                {dir_x, dir_y, dir_z} <= {w.d[0], w.d[1], w.d[2]};
                {quat_w, quat_x, quat_y, quat_z} <= {w.q[0], w.q[1], w.q[2], w.q[3]};
                {center_x, center_y, center_z} <= {w.c[0], w.c[1], w.c[2]};
                req_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    task automatic reg_write(input logic sel, input logic [30:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {sel, 2'b00};
        pwdata <= {$urandom_range(0, 1) == 1, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic add_query(input logic signed [31:0] dx, dy, dz,
                             input logic signed [15:0] qw, qx, qy, qz,
                             input logic signed [31:0] cx, cy, cz);
        query_t w;
        w.d = '{dx, dy, dz};
        w.q = '{qw, qx, qy, qz};
        w.c = '{cx, cy, cz};
        query_q.push_back(w);
    endtask

    function automatic logic signed [31:0] rand_coord();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    task automatic add_random(input int count);
        query_t w;
        real a, b, c, e, n;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    w.d[j] = $urandom;
                    w.c[j] = $urandom;
                end
                for (int j = 0; j < 4; j++)
                    w.q[j] = 16'($urandom);
            end
            else
            begin
                a = $itor($urandom_range(0, 65535)) - 32768.0;
                b = $itor($urandom_range(0, 65535)) - 32768.0;
                c = $itor($urandom_range(0, 65535)) - 32768.0;
                e = $itor($urandom_range(0, 65535)) - 32768.0;
                n = $sqrt(a * a + b * b + c * c + e * e) + 1.0;
                w.q = '{16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                        16'($rtoi(c / n * 16384.0)), 16'($rtoi(e / n * 16384.0))};
                for (int j = 0; j < 3; j++)
                begin
                    w.d[j] = rand_coord();
                    w.c[j] = ($urandom_range(0, 9) == 0) ? $urandom : rand_coord();
                end
            end
            query_q.push_back(w);
        end
    endtask

    task automatic drain();
        while (query_q.size() != 0 || req_valid || pending != 0 || req_ready === 1'b0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    localparam logic signed [15:0] QONE = 16'sd16384;
    localparam logic signed [31:0] FONE = 32'sd65536;
    localparam logic signed [31:0] IMAX = 32'sh7fffffff;
    localparam logic signed [31:0] IMIN = 32'sh80000000;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        reg_write(csp_pkg::REG_RADIUS, 31'd65536);
        reg_write(csp_pkg::REG_HEIGHT, 31'd131072);
        // short direction and near threshold
        add_query(0, 0, 0, QONE, 0, 0, 0, FONE, -FONE, 5);
        add_query(32, 32, 32, QONE, 0, 0, 0, 1, 2, 3);
        add_query(38, 0, 0, QONE, 0, 0, 0, 0, 0, 0);
        // tip, base, sideways, ties
        add_query(0, FONE, 0, QONE, 0, 0, 0, 0, 0, 0);
        add_query(0, -FONE, 0, QONE, 0, 0, 0, 0, 0, 0);
        add_query(FONE, 0, 0, QONE, 0, 0, 0, 0, 0, 0);
        add_query(0, 0, -FONE, QONE, 0, 0, 0, 0, 0, 0);
        add_query(FONE, FONE, 0, QONE, 0, 0, 0, 0, 0, 0);
        add_query(-FONE, -FONE, FONE, QONE, 0, 0, 0, 0, 0, 0);
        // quarter turns and a non-unit quaternion
        add_query(0, FONE, 0, 16'sd11585, 16'sd11585, 0, 0, FONE, 0, 0);
        add_query(FONE, 0, FONE, 16'sd11585, 0, 0, -16'sd11585, 0, FONE, 0);
        add_query(FONE, FONE, FONE, 16'sd20000, 16'sd3000, -16'sd7000, 16'sd100, 0, 0, 0);
        // extremes
        add_query(IMAX, IMAX, IMAX, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, IMAX, IMAX, IMAX);
        add_query(IMIN, IMIN, IMIN, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, IMIN, IMIN, IMIN);
        add_query(IMAX, IMIN, IMAX, 16'sh8000, 0, 16'sh7fff, 0, IMIN, IMAX, IMIN);
        add_query(0, IMIN, 0, QONE, 0, 0, 0, IMAX, IMAX, IMAX);
        add_query(0, FONE, 0, QONE, 0, 0, 0, IMAX, IMIN, IMAX);
        add_query(-1, -1, -1, 16'shffff, 16'shffff, 16'shffff, 16'shffff, -1, -1, -1);
        add_random(110);
        drain();

        reg_write(csp_pkg::REG_RADIUS, 31'd0);
        reg_write(csp_pkg::REG_HEIGHT, 31'h7fffffff);
        add_query(FONE, -FONE, FONE, QONE, 0, 0, 0, 0, 0, 0);
        add_query(FONE, 0, 0, QONE, 0, 0, 0, 0, 0, 0);
        add_random(120);
        drain();

        reg_write(csp_pkg::REG_RADIUS, 31'h7fffffff);
        reg_write(csp_pkg::REG_HEIGHT, 31'h7fffffff);
        add_random(120);
        drain();

        reg_write(csp_pkg::REG_RADIUS, 31'h7fffffff);
        reg_write(csp_pkg::REG_HEIGHT, 31'd0);
        add_query(0, FONE, 0, QONE, 0, 0, 0, 0, 0, 0);
        add_random(120);
        drain();

        reg_write(csp_pkg::REG_RADIUS, 31'($urandom_range(1, 1 << 20)));
        reg_write(csp_pkg::REG_HEIGHT, 31'($urandom_range(1, 1 << 20)));
        add_random(130);
        drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
